### design/modbus_rtu_frame_checker_unit_assert.svh
// Assertion macros for the Modbus RTU frame checker.
// Included by the top level; no other dependencies.
`ifndef MODBUS_RTU_FRAME_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_RTU_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MRFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrfc assertion failed");

// next-cycle implication, disabled in reset
`define MRFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrfc assertion failed");

`endif

### design/mrfc_pkg.sv
// Shared types, codes and CRC-16/MODBUS table for the Modbus RTU frame checker.
// No dependencies.
package mrfc_pkg;

  localparam int MAX_FRAME_DEF = 256;
  localparam int LEN_W         = 9;
  localparam int VERDICT_W     = 3;

  localparam logic [VERDICT_W-1:0] VERDICT_SUPPORTED   = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_UNSUPPORTED = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OTHER_STA   = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_CRC_ERR     = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_SHORT   = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_LONG    = 3'd5;

  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

  localparam logic [7:0]  STATION_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [7:0]           function_code;
    logic [LEN_W-1:0]     frame_length;
    logic [15:0]          computed_crc;
  } out_item_t;

  // one entry of the 256-entry reflected CRC table
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    return {8'h00, crc[15:8]} ^ crc_table(crc[7:0] ^ b);
  endfunction

endpackage

### design/mrfc_frame_eval.sv
// Per-frame state and verdict logic: CRC accumulator, byte counter, header bytes.
// Depends on mrfc_pkg.
module mrfc_frame_eval #(
  parameter int MaxFrame = mrfc_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  mrfc_pkg::in_item_t  item,
  input  logic [7:0]          station_address,
  output mrfc_pkg::out_item_t result
);

  localparam int CNT_W = $clog2(MaxFrame + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MaxFrame);

  logic [15:0]      crc_r, crc_nxt, crc_upd;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, len;
  logic [7:0]       station_r, station_nxt, sta;
  logic [7:0]       function_r, function_nxt, fc;
  logic [15:0]      trail_r, trail_nxt, trail_new, received;
  logic             overlong_r, overlong_nxt, too_long, too_short;
  logic             fc_known;

  always_comb begin
    too_long  = overlong_r || (cnt_r == MAX_CNT);
    len       = (cnt_r == MAX_CNT) ? MAX_CNT : cnt_r + CNT_W'(1);
    too_short = cnt_r < CNT_W'(3);
    sta       = (cnt_r == '0) ? item.frame_byte : station_r;
    fc        = (cnt_r == CNT_W'(1)) ? item.frame_byte : function_r;
    // CRC trails input by two bytes; the final pair is the received CRC
    crc_upd   = (cnt_r >= CNT_W'(2)) ? mrfc_pkg::crc_step(crc_r, trail_r[15:8]) : crc_r;
    trail_new = {trail_r[7:0], item.frame_byte};
    received  = {trail_new[7:0], trail_new[15:8]};
    fc_known  = (fc == mrfc_pkg::FC_READ_HOLDING) || (fc == mrfc_pkg::FC_READ_INPUT) ||
                (fc == mrfc_pkg::FC_WRITE_SINGLE) || (fc == mrfc_pkg::FC_WRITE_MULTI);

    if (too_short) begin
      result.verdict = mrfc_pkg::VERDICT_TOO_SHORT;
    end else if (too_long) begin
      result.verdict = mrfc_pkg::VERDICT_TOO_LONG;
    end else if (sta != station_address) begin
      result.verdict = mrfc_pkg::VERDICT_OTHER_STA;
    end else if (received != crc_upd) begin
      result.verdict = mrfc_pkg::VERDICT_CRC_ERR;
    end else if (fc_known) begin
      result.verdict = mrfc_pkg::VERDICT_SUPPORTED;
    end else begin
      result.verdict = mrfc_pkg::VERDICT_UNSUPPORTED;
    end
    result.function_code = fc;
    result.frame_length  = mrfc_pkg::LEN_W'(len);
    result.computed_crc  = {crc_upd[7:0], crc_upd[15:8]};

    crc_nxt      = crc_r;
    cnt_nxt      = cnt_r;
    station_nxt  = station_r;
    function_nxt = function_r;
    trail_nxt    = trail_r;
    overlong_nxt = overlong_r;
    if (fire) begin
      if (item.last_byte) begin
        crc_nxt      = mrfc_pkg::CRC_INIT;
        cnt_nxt      = '0;
        station_nxt  = '0;
        function_nxt = '0;
        trail_nxt    = '0;
        overlong_nxt = 1'b0;
      end else begin
        crc_nxt      = crc_upd;
        cnt_nxt      = len;
        station_nxt  = sta;
        function_nxt = fc;
        trail_nxt    = trail_new;
        overlong_nxt = too_long;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= mrfc_pkg::CRC_INIT;
      cnt_r      <= '0;
      station_r  <= '0;
      function_r <= '0;
      trail_r    <= '0;
      overlong_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      cnt_r      <= cnt_nxt;
      station_r  <= station_nxt;
      function_r <= function_nxt;
      trail_r    <= trail_nxt;
      overlong_r <= overlong_nxt;
    end
  end

endmodule

### design/modbus_rtu_frame_checker_unit.sv
// Modbus RTU frame checker: takes one received byte per cycle and, on the byte
// flagged last, returns one verdict with function code, length and CRC-16/MODBUS.
// An item passes an input register, then CRC table lookup and compare logic,
// then the result register. The sustained rate is one byte per cycle, but in_stall
// holds the input while a last byte waits. Bytes that are not
// last leave no result and advance even while a result waits; only a last byte
// waits for the result register to free up. The station address register
// resets to 1 and may be rewritten while no frame is in flight.
// Depends on mrfc_pkg, mrfc_frame_eval and modbus_rtu_frame_checker_unit_assert.svh.
`include "modbus_rtu_frame_checker_unit_assert.svh"

module modbus_rtu_frame_checker_unit #(
  parameter int MaxFrame = mrfc_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mrfc_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  logic               in_vld_r, in_vld_nxt;
  mrfc_pkg::in_item_t in_item_r;
  logic               out_vld_r, out_vld_nxt;
  mrfc_pkg::out_item_t out_item_r, eval_res;
  logic [7:0]         station_r;
  logic               out_free, fire, in_take;

  always_comb begin
    out_free    = !out_vld_r || !out_stall;
    fire        = in_vld_r && (!in_item_r.last_byte || out_free);
    in_stall    = in_vld_r && !fire;
    in_take     = in_valid && !in_stall;
    in_vld_nxt  = in_take || (in_vld_r && !fire);
    out_vld_nxt = (fire && in_item_r.last_byte) || (out_vld_r && out_stall);
  end

  mrfc_frame_eval #(.MaxFrame(MaxFrame)) u_eval (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .item            (in_item_r),
    .station_address (station_r),
    .result          (eval_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      station_r <= mrfc_pkg::STATION_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        station_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (fire && in_item_r.last_byte) begin
      out_item_r <= eval_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  `MRFC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_r && !fire, in_vld_r)
  `MRFC_ASSERT_NOW(a_no_overwrite, clk, rst_n,
    out_vld_r && out_stall, !(fire && in_item_r.last_byte))
  `MRFC_ASSERT_NOW(a_short_len, clk, rst_n,
    out_valid && out_data.verdict == mrfc_pkg::VERDICT_TOO_SHORT,
    out_data.frame_length < mrfc_pkg::LEN_W'(4))
  `MRFC_ASSERT_NOW(a_long_len, clk, rst_n,
    out_valid && out_data.verdict == mrfc_pkg::VERDICT_TOO_LONG,
    out_data.frame_length == mrfc_pkg::LEN_W'(MaxFrame))

endmodule

### verif/tb.sv
// Testbench for modbus_rtu_frame_checker_unit: frames with good and bad CRC, short and long
// frames and station changes, checked against a cycle-free model of the verdict logic.
// Depends on mrfc_pkg and the design sources.
`timescale 1ns / 100ps

module tb;
  import mrfc_pkg::*;

  localparam int MAX_FRAME    = MAX_FRAME_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RX_HOLD_CYC  = 300;
  localparam int RANDOM_BYTES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic [7:0] cfg_wr_data;

  modbus_rtu_frame_checker_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // model state
  logic [7:0]  station_cfg;
  logic [15:0] mdl_crc;
  int          mdl_count;
  logic [7:0]  mdl_station;
  logic [7:0]  mdl_func;
  logic [15:0] mdl_pair;
  logic        mdl_overlong;

  out_item_t   expected_verdicts[$];
  logic [7:0]  frame_buf[$];
  int          fail_cnt;
  int          cycle_cnt;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic clear_frame_state();
    mdl_crc      = CRC_INIT;
    mdl_count    = 0;
    mdl_station  = 8'h00;
    mdl_func     = 8'h00;
    mdl_pair     = 16'h0000;
    mdl_overlong = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic is_last);
    int          cnt;
    int          len;
    logic        too_long;
    logic [15:0] rcvd;
    out_item_t   res;
    cnt      = mdl_count;
    too_long = mdl_overlong || (cnt >= MAX_FRAME);
    len      = (cnt + 1 >= MAX_FRAME) ? MAX_FRAME : cnt + 1;
    if (cnt == 0) mdl_station = b;
    else if (cnt == 1) mdl_func = b;
    // the two newest bytes are held back from the CRC
    if (cnt >= 2) mdl_crc = crc16_feed(mdl_crc, mdl_pair[15:8]);
    mdl_pair = {mdl_pair[7:0], b};
    if (!is_last) begin
      mdl_count    = len;
      mdl_overlong = too_long;
    end else begin
      rcvd = {mdl_pair[7:0], mdl_pair[15:8]};
      if (cnt + 1 < 4) res.verdict = VERDICT_TOO_SHORT;
      else if (too_long) res.verdict = VERDICT_TOO_LONG;
      else if (mdl_station != station_cfg) res.verdict = VERDICT_OTHER_STA;
      else if (rcvd != mdl_crc) res.verdict = VERDICT_CRC_ERR;
      else if (mdl_func == FC_READ_HOLDING || mdl_func == FC_READ_INPUT ||
               mdl_func == FC_WRITE_SINGLE || mdl_func == FC_WRITE_MULTI)
        res.verdict = VERDICT_SUPPORTED;
      else res.verdict = VERDICT_UNSUPPORTED;
      res.function_code = mdl_func;
      res.frame_length  = len[LEN_W-1:0];
      res.computed_crc  = {mdl_crc[7:0], mdl_crc[15:8]};
      expected_verdicts.push_back(res);
      clear_frame_state();
    end
  endtask

  // called right after the previous transfer edge; drives valid exactly once per step
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = (!tx_idle_en || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{frame_byte: b, last_byte: is_last};
    do @(posedge clk); while (in_stall);
    predict_byte(b, is_last);
  endtask

  task automatic drive_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // station, function, payload, then CRC low byte and high byte
  task automatic build_frame(input logic [7:0] sta, input logic [7:0] fc, input int n_data);
    logic [15:0] crc;
    frame_buf.delete();
    frame_buf.push_back(sta);
    frame_buf.push_back(fc);
    for (int i = 0; i < n_data; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    crc = CRC_INIT;
    foreach (frame_buf[i]) crc = crc16_feed(crc, frame_buf[i]);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_station(input logic [7:0] a);
    wait_idle();
    cfg_wr_data <= a;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    station_cfg = a;
  endtask

  function automatic logic [7:0] pick_func();
    case ($urandom_range(0, 5))
      0: return FC_READ_HOLDING;
      1: return FC_READ_INPUT;
      2: return FC_WRITE_SINGLE;
      3: return FC_WRITE_MULTI;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(0, 8);
    else if (r < 98) return $urandom_range(9, 40);
    else return $urandom_range(41, 120);
  endfunction

  task automatic random_frame(output int n_bytes);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      build_frame(station_cfg, pick_func(), pick_payload_len());
    end else if (r < 65) begin
      build_frame(station_cfg ^ 8'($urandom_range(1, 255)), pick_func(), pick_payload_len());
    end else if (r < 78) begin
      // good frame with one byte damaged
      build_frame(station_cfg, pick_func(), pick_payload_len());
      n = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
    end else if (r < 88) begin
      frame_buf.delete();
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) frame_buf[0] = station_cfg;
    end else begin
      frame_buf.delete();
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    n_bytes = frame_buf.size();
    drive_frame();
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_station();
    build_frame(STATION_RESET, FC_READ_HOLDING, 0); drive_frame();
    build_frame(STATION_RESET, FC_READ_INPUT, 0);   drive_frame();
    build_frame(STATION_RESET, FC_WRITE_SINGLE, 0); drive_frame();
    build_frame(STATION_RESET, FC_WRITE_MULTI, 0);  drive_frame();
    build_frame(STATION_RESET, 8'h05, 0);           drive_frame();
    build_frame(8'h02, FC_READ_HOLDING, 0);         drive_frame();
    build_frame(STATION_RESET, FC_READ_HOLDING, 0);
    frame_buf[3] = frame_buf[3] ^ 8'h80;
    drive_frame();
    wait_idle();
  endtask

  task automatic test_short_frames();
    frame_buf = '{8'h01};
    drive_frame();
    frame_buf = '{8'h01, 8'h03};
    drive_frame();
    frame_buf = '{8'h01, 8'h03, 8'hFF};
    drive_frame();
    wait_idle();
  endtask

  task automatic test_station_extremes();
    write_station(8'h00);
    build_frame(8'h00, 8'h00, 1);
    frame_buf[2] = 8'hFF;
    drive_frame();
    build_frame(8'h01, FC_READ_HOLDING, 0); drive_frame();
    write_station(8'hFF);
    build_frame(8'hFF, FC_WRITE_MULTI, 0);  drive_frame();
    build_frame(8'hFF, 8'hFF, 0);           drive_frame();
    write_station(STATION_RESET);
    wait_idle();
  endtask

  task automatic test_length_limits();
    // exactly MAX_FRAME bytes is accepted, one more is too long
    build_frame(station_cfg, FC_WRITE_MULTI, MAX_FRAME - 4);  drive_frame();
    build_frame(station_cfg, FC_WRITE_MULTI, MAX_FRAME - 3);  drive_frame();
    build_frame(station_cfg, FC_READ_INPUT, MAX_FRAME + 10);  drive_frame();
    build_frame(station_cfg, FC_READ_INPUT, 0);               drive_frame();
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    for (int phase = 0; phase < 4; phase++) begin
      write_station(8'($urandom_range(0, 255)));
      // one phase runs without any idling on either side
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      sent = 0;
      while (sent < RANDOM_BYTES / 4) begin
        random_frame(n);
        sent += n;
      end
      wait_idle();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      build_frame(station_cfg, pick_func(), $urandom_range(0, 2));
      drive_frame();
    end
    wait_idle();
    tx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYC) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        if (fail_cnt < 10) $display("tb: unexpected result %p", out_data);
        fail_cnt++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.verdict !== want.verdict ||
            out_data.function_code !== want.function_code ||
            out_data.frame_length !== want.frame_length ||
            out_data.computed_crc !== want.computed_crc) begin
          if (fail_cnt < 10)
            $display("tb: mismatch exp v=%0d fc=%h len=%0d crc=%h, got v=%0d fc=%h len=%0d crc=%h",
                     want.verdict, want.function_code, want.frame_length, want.computed_crc,
                     out_data.verdict, out_data.function_code, out_data.frame_length,
                     out_data.computed_crc);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    fail_cnt    = 0;
    cycle_cnt   = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    rx_hold_req = 1'b0;
    station_cfg = STATION_RESET;
    clear_frame_state();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_station();
    test_short_frames();
    test_station_extremes();
    test_length_limits();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### modbus_rtu_frame_checker_unit.f
+incdir+design
design/mrfc_pkg.sv
design/mrfc_frame_eval.sv
design/modbus_rtu_frame_checker_unit.sv
verif/tb.sv
